FILE: hw/rtl/csed_pkg.sv
// Shared types and constants of the compact score event decoder.
package csed_pkg;

  // Kinds of decoded event.
  typedef enum logic [2:0] {
    KIND_EMPTY       = 3'd0,
    KIND_NOTE_ON     = 3'd1,
    KIND_CTRL_CHANGE = 3'd2,
    KIND_PROG_CHANGE = 3'd3,
    KIND_PITCH_BEND  = 3'd4
  } kind_t;

  // Byte codes that steer the parser.
  localparam logic [7:0] BYTE_CTRL_START = 8'h00;
  localparam logic [7:0] BYTE_ESCAPE     = 8'hFF;
  localparam logic [7:0] BYTE_EXCL_START = 8'hF0;
  localparam logic [7:0] BYTE_EXCL_END   = 8'hF7;

  // Two-byte control types, bits 5..4 of the control byte.
  localparam logic [1:0] CT2_EXPRESSION = 2'd0;
  localparam logic [1:0] CT2_UNUSED     = 2'd1;
  localparam logic [1:0] CT2_MODULATION = 2'd2;
  localparam logic [1:0] CT2_LONG_FORM  = 2'd3;

  // Three-byte control types, bits 3..0 of the control byte.
  localparam logic [3:0] CT3_PROGRAM    = 4'h0;
  localparam logic [3:0] CT3_BANK       = 4'h1;
  localparam logic [3:0] CT3_MODULATION = 4'h3;
  localparam logic [3:0] CT3_VOLUME     = 4'h7;
  localparam logic [3:0] CT3_PAN        = 4'hA;
  localparam logic [3:0] CT3_EXPRESSION = 4'hB;

  // Controller numbers on the output.
  localparam logic [6:0] CTRL_BANK       = 7'd0;
  localparam logic [6:0] CTRL_MODULATION = 7'd1;
  localparam logic [6:0] CTRL_VOLUME     = 7'd7;
  localparam logic [6:0] CTRL_PAN        = 7'd10;
  localparam logic [6:0] CTRL_EXPRESSION = 7'd11;

  localparam logic [13:0] BEND_CENTRE   = 14'h2000;
  localparam logic [6:0]  VELOCITY_FULL = 7'd127;
  localparam logic [6:0]  NOTE_LOWEST   = 7'd36;
  localparam logic [6:0]  NOTE_HIGHEST  = 7'd87;

  // One input request.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       final_byte;
  } in_item_t;

  // One decoded event.
  typedef struct packed {
    logic [13:0] delta_ticks;
    kind_t       event_kind;
    logic [3:0]  channel_number;
    logic [6:0]  note_number;
    logic [6:0]  note_velocity;
    logic [13:0] gate_ticks;
    logic [6:0]  controller_number;
    logic [7:0]  controller_value;
    logic [7:0]  program_number;
    logic [13:0] bend_value;
  } result_t;

endpackage

FILE: hw/rtl/csed_in_if.sv
// Request channel carrying score bytes into the decoder.
interface csed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       final_byte;

  modport source (output valid, output byte_value, output final_byte, input ready);
  modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface

FILE: hw/rtl/csed_out_if.sv
// Request channel carrying decoded events out of the decoder.
interface csed_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] delta_ticks;
  logic [2:0]  event_kind;
  logic [3:0]  channel_number;
  logic [6:0]  note_number;
  logic [6:0]  note_velocity;
  logic [13:0] gate_ticks;
  logic [6:0]  controller_number;
  logic [7:0]  controller_value;
  logic [7:0]  program_number;
  logic [13:0] bend_value;

  modport source (
    output valid, output delta_ticks, output event_kind, output channel_number,
    output note_number, output note_velocity, output gate_ticks,
    output controller_number, output controller_value, output program_number,
    output bend_value, input ready
  );
  modport sink (
    input valid, input delta_ticks, input event_kind, input channel_number,
    input note_number, input note_velocity, input gate_ticks,
    input controller_number, input controller_value, input program_number,
    input bend_value, output ready
  );
endinterface

FILE: hw/rtl/csed_parser.sv
// Parser state machine: consumes one score byte per step and forms at most one event.
module csed_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  csed_pkg::in_item_t item,
  input  logic [1:0]         track_number,
  output logic               result_valid,
  output csed_pkg::result_t  result
);

  typedef enum logic [3:0] {
    PH_DELTA, PH_EVENT, PH_CTRL, PH_VALUE, PH_ESC, PH_XLEN, PH_SKIP, PH_TERM, PH_GATE
  } phase_t;

  phase_t      phase, phase_next;
  logic [13:0] delta, delta_next;
  logic [13:0] gate, gate_next;
  logic        group_count, group_count_next;
  logic [3:0]  held_ctrl, held_ctrl_next;
  logic [6:0]  held_note, held_note_next;
  logic [3:0]  held_channel, held_channel_next;
  logic [7:0]  skip_remaining, skip_remaining_next;

  logic [7:0]  b;
  logic        fin;
  logic [3:0]  chan;
  logic [3:0]  chan_offset;
  logic [6:0]  octave_base;
  logic [6:0]  note;

  assign b   = item.byte_value;
  assign fin = item.final_byte;

  // Tracks from 2 upward move the channels up by four per track step.
  assign chan_offset = (track_number >= 2'd2) ? {track_number - 2'd1, 2'b00} : 4'd0;
  assign chan        = {2'b00, b[7:6]} + chan_offset;

  always_comb begin
    case (b[5:4])
      2'd0:    octave_base = 7'd36;
      2'd1:    octave_base = 7'd48;
      2'd2:    octave_base = 7'd60;
      default: octave_base = 7'd72;
    endcase
  end
  assign note = octave_base + {3'b000, b[3:0]};

  always_comb begin
    phase_next          = phase;
    delta_next          = delta;
    gate_next           = gate;
    group_count_next    = group_count;
    held_ctrl_next      = held_ctrl;
    held_note_next      = held_note;
    held_channel_next   = held_channel;
    skip_remaining_next = skip_remaining;
    result_valid        = 1'b0;
    result              = '0;
    result.delta_ticks  = delta;
    result.event_kind   = csed_pkg::KIND_EMPTY;

    case (phase)
      PH_TERM: begin
        // An end marker after an exclusive payload is swallowed; anything else
        // opens the next delta time.
        group_count_next = 1'b0;
        if (b == csed_pkg::BYTE_EXCL_END) begin
          phase_next = PH_DELTA;
        end else begin
          delta_next       = {7'd0, b[6:0]};
          group_count_next = b[7];
          phase_next       = b[7] ? PH_DELTA : PH_EVENT;
        end
      end
      PH_DELTA: begin
        if (!group_count) begin
          delta_next       = {7'd0, b[6:0]};
          group_count_next = b[7];
          phase_next       = b[7] ? PH_DELTA : PH_EVENT;
        end else begin
          delta_next       = {delta[6:0], b[6:0]};
          group_count_next = 1'b0;
          phase_next       = PH_EVENT;
        end
      end
      PH_EVENT: begin
        if (b == csed_pkg::BYTE_CTRL_START) begin
          phase_next = PH_CTRL;
        end else if (b == csed_pkg::BYTE_ESCAPE) begin
          phase_next = PH_ESC;
        end else begin
          held_channel_next = chan;
          held_note_next    = note;
          gate_next         = '0;
          group_count_next  = 1'b0;
          phase_next        = PH_GATE;
          if (fin) begin
            result_valid          = 1'b1;
            result.event_kind     = csed_pkg::KIND_NOTE_ON;
            result.channel_number = chan;
            result.note_number    = note;
            result.note_velocity  = csed_pkg::VELOCITY_FULL;
          end
        end
      end
      PH_GATE: begin
        if (!group_count) begin
          gate_next = {7'd0, b[6:0]};
        end else begin
          gate_next = {gate[6:0], b[6:0]};
        end
        if (!group_count && b[7] && !fin) begin
          group_count_next = 1'b1;
        end else begin
          result_valid          = 1'b1;
          result.event_kind     = csed_pkg::KIND_NOTE_ON;
          result.channel_number = held_channel;
          result.note_number    = held_note;
          result.note_velocity  = csed_pkg::VELOCITY_FULL;
          result.gate_ticks     = gate_next;
          group_count_next      = 1'b0;
          phase_next            = PH_DELTA;
        end
      end
      PH_CTRL: begin
        held_ctrl_next    = b[3:0];
        held_channel_next = chan;
        phase_next        = PH_DELTA;
        case (b[5:4])
          csed_pkg::CT2_EXPRESSION: begin
            result_valid             = 1'b1;
            result.event_kind        = csed_pkg::KIND_CTRL_CHANGE;
            result.channel_number    = chan;
            result.controller_number = csed_pkg::CTRL_EXPRESSION;
            result.controller_value  = {1'b0, b[3:0], 3'b000};
          end
          csed_pkg::CT2_MODULATION: begin
            result_valid             = 1'b1;
            result.event_kind        = csed_pkg::KIND_CTRL_CHANGE;
            result.channel_number    = chan;
            result.controller_number = csed_pkg::CTRL_MODULATION;
            result.controller_value  = {4'd0, b[3:0]};
          end
          csed_pkg::CT2_UNUSED: begin
            result_valid = 1'b1;
          end
          default: begin
            // Bits 5..4 both set: a value byte follows.
            phase_next = PH_VALUE;
          end
        endcase
      end
      PH_VALUE: begin
        result_valid          = 1'b1;
        result.channel_number = held_channel;
        result.event_kind     = csed_pkg::KIND_CTRL_CHANGE;
        result.controller_value = b;
        phase_next            = PH_DELTA;
        case (held_ctrl)
          csed_pkg::CT3_PROGRAM: begin
            result.event_kind       = csed_pkg::KIND_PROG_CHANGE;
            result.controller_value = '0;
            result.program_number   = b;
          end
          csed_pkg::CT3_BANK:       result.controller_number = csed_pkg::CTRL_BANK;
          csed_pkg::CT3_MODULATION: result.controller_number = csed_pkg::CTRL_MODULATION;
          csed_pkg::CT3_VOLUME:     result.controller_number = csed_pkg::CTRL_VOLUME;
          csed_pkg::CT3_PAN:        result.controller_number = csed_pkg::CTRL_PAN;
          csed_pkg::CT3_EXPRESSION: result.controller_number = csed_pkg::CTRL_EXPRESSION;
          default: begin
            result.event_kind       = csed_pkg::KIND_EMPTY;
            result.channel_number   = '0;
            result.controller_value = '0;
          end
        endcase
      end
      PH_ESC: begin
        if (b != csed_pkg::BYTE_EXCL_START) begin
          result_valid = 1'b1;
          phase_next   = PH_DELTA;
        end else begin
          phase_next = PH_XLEN;
        end
      end
      PH_XLEN: begin
        skip_remaining_next = b;
        phase_next          = (b == 8'd0) ? PH_TERM : PH_SKIP;
      end
      PH_SKIP: begin
        skip_remaining_next = skip_remaining - 8'd1;
        if (skip_remaining == 8'd1) begin
          phase_next = PH_TERM;
        end
      end
      default: begin
        phase_next          = PH_DELTA;
        group_count_next    = 1'b0;
        delta_next          = '0;
        gate_next           = '0;
        skip_remaining_next = '0;
      end
    endcase

    // The last byte of a chunk always returns the parser to idle.
    if (fin) begin
      phase_next          = PH_DELTA;
      group_count_next    = 1'b0;
      delta_next          = '0;
      gate_next           = '0;
      skip_remaining_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      delta          <= '0;
      gate           <= '0;
      group_count    <= 1'b0;
      held_ctrl      <= '0;
      held_note      <= '0;
      held_channel   <= '0;
      skip_remaining <= '0;
    end else if (step) begin
      phase          <= phase_next;
      delta          <= delta_next;
      gate           <= gate_next;
      group_count    <= group_count_next;
      held_ctrl      <= held_ctrl_next;
      held_note      <= held_note_next;
      held_channel   <= held_channel_next;
      skip_remaining <= skip_remaining_next;
    end
  end

`ifndef NO_ASSERTIONS
  // While skipping an exclusive payload there is always at least one byte left.
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_remaining != 8'd0)
    else $error("skip phase with nothing left to skip");

  // A final byte always leaves the parser idle with cleared accumulators.
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    step && fin |=> phase == PH_DELTA && delta == '0 && !group_count)
    else $error("parser not idle after final byte");
`endif

endmodule

FILE: hw/rtl/compact_score_event_decoder.sv
// Top level of the compact score event decoder: input register, parser and result register.
//
// The decoder takes one byte of a compact score sequence per request, with
// final_byte marking the last byte of a chunk, and emits zero or one decoded
// event per byte: note on, control change, program change or an empty event
// carrying only its delta time. It sustains one byte per clock cycle while
// the output is not stalled. A byte is held in the input register when it is
// accepted and decoded from there, and its event, if any, is loaded into the
// result register when the parser consumes the byte, which a stalled output
// can hold back. The parser between the two registers is a single short
// decode stage whose state advances once per byte. The input register and
// the result register decouple the two sides: while a finished event waits
// to be taken, one further byte can still be accepted into the input
// register, and a stalled output then holds that byte without losing or
// repeating anything. Bytes that complete no event (delta groups, escape
// prefixes, skipped exclusive payloads) produce no output request. The track
// number register shifts channels by four per track step from track 2 upward
// and may only be written while the decoder is idle.
module compact_score_event_decoder (
  input  logic       clk,
  input  logic       rst,
  csed_in_if.sink    in_chan,
  csed_out_if.source out_chan,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);

  logic               in_valid;
  csed_pkg::in_item_t in_item;
  logic               out_valid;
  csed_pkg::result_t  out_item;
  logic [1:0]         track_number;

  logic               step;
  logic               res_valid;
  csed_pkg::result_t  res;

  // The parser consumes the held byte whenever the result slot is free or
  // is being emptied in this cycle.
  assign step         = in_valid && (!out_valid || out_chan.ready);
  assign in_chan.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_number <= '0;
    end else if (cfg_wr_en) begin
      track_number <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item.byte_value <= in_chan.byte_value;
      in_item.final_byte <= in_chan.final_byte;
    end
  end

  csed_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .item         (in_item),
    .track_number (track_number),
    .result_valid (res_valid),
    .result       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_valid;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_item <= res;
    end
  end

  assign out_chan.valid             = out_valid;
  assign out_chan.delta_ticks       = out_item.delta_ticks;
  assign out_chan.event_kind        = out_item.event_kind;
  assign out_chan.channel_number    = out_item.channel_number;
  assign out_chan.note_number       = out_item.note_number;
  assign out_chan.note_velocity     = out_item.note_velocity;
  assign out_chan.gate_ticks        = out_item.gate_ticks;
  assign out_chan.controller_number = out_item.controller_number;
  assign out_chan.controller_value  = out_item.controller_value;
  assign out_chan.program_number    = out_item.program_number;
  assign out_chan.bend_value        = out_item.bend_value;

`ifndef NO_ASSERTIONS
  // A result only appears after the parser has consumed a byte.
  a_out_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step))
    else $error("result appeared without a parser step");

  // Empty events carry nothing but their delta time.
  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.event_kind == csed_pkg::KIND_EMPTY |->
      out_item.channel_number == '0 && out_item.bend_value == '0 &&
      out_item.controller_value == '0 && out_item.note_velocity == '0)
    else $error("empty event carries payload");

  // Notes have full velocity and a note number in the range a note byte can reach.
  a_note_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.event_kind == csed_pkg::KIND_NOTE_ON |->
      out_item.note_velocity == csed_pkg::VELOCITY_FULL &&
      out_item.note_number >= csed_pkg::NOTE_LOWEST &&
      out_item.note_number <= csed_pkg::NOTE_HIGHEST)
    else $error("malformed note event");
`endif

endmodule
